[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the CRC-32 frame block.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_NO_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/crc32fc_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 update for the frame block.
// No dependencies.
package crc32fc_pkg;

   localparam int BYTE_W     = 8;
   localparam int CRC_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] REG_OPERATION_MODE = '0;

   typedef enum logic {
      MODE_CHECK = 1'b0,
      MODE_SEAL  = 1'b1
   } mode_type;

   // Input stage contents handed to the frame logic.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
   } stage_type;

   // Reflected CRC-32, one byte per call (eight shift/xor steps).
   function automatic logic [CRC_W-1:0] crc_byte_update(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

[rtl/crc32fc_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on crc32fc_pkg.
interface crc32fc_req_if;
   import crc32fc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface crc32fc_rsp_if;
   import crc32fc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              frame_end;
   logic              frame_ok;

   modport source (output valid, output out_byte, output frame_end, output frame_ok,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_end, input frame_ok,
                   output ready);
endinterface

[rtl/crc32fc_csr.sv]
// APB-style register port holding operation_mode.
// Depends on crc32fc_pkg.
module crc32fc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crc32fc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [crc32fc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [crc32fc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready,
   output crc32fc_pkg::mode_type               mode
);
   import crc32fc_pkg::*;

   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   mode_type             mode_ff;
   mode_type             mode_in;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mode       = mode_ff;

   always_comb begin
      mode_in = mode_ff;
      if (wr_en && (reg_idx == REG_OPERATION_MODE)) begin
         mode_in = mode_type'(csr_pwdata[0]);
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OPERATION_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CHECK;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

[rtl/crc32fc_in_stage.sv]
// Input register: captures one request item, frees itself when the frame logic takes it.
// Depends on crc32fc_pkg and crc32fc_req_if.
module crc32fc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   crc32fc_req_if.sink            req_chan,
   input  logic                   take,
   output crc32fc_pkg::stage_type stage
);
   import crc32fc_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   assign stage.valid     = valid_ff;
   assign stage.data_byte = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_chan.data_byte;
      end
   end

endmodule

[rtl/crc32fc_frame.sv]
// Frame state (CRC, position, first-byte match) and the response register.
// Depends on crc32fc_pkg and crc32fc_rsp_if.
module crc32fc_frame #(
   parameter int FRAME_LEN = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crc32fc_pkg::stage_type stage,
   input  crc32fc_pkg::mode_type  mode,
   output logic                   take,
   crc32fc_rsp_if.source          rsp_chan
);
   import crc32fc_pkg::*;

   localparam int             POS_W    = $clog2(FRAME_LEN);
   localparam logic [POS_W-1:0] POS_CRC0 = POS_W'(FRAME_LEN - 2);

   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              first_ff, first_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              frame_end_ff, frame_end_in;
   logic              frame_ok_ff, frame_ok_in;
   logic [CRC_W-1:0]  crc_fin;
   logic              seal;

   assign take    = stage.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign crc_fin = ~crc_ff;
   assign seal    = (mode == MODE_SEAL);

   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      out_byte_in  = stage.data_byte;
      frame_end_in = 1'b0;
      frame_ok_in  = 1'b0;
      if (pos_ff < POS_CRC0) begin
         // payload byte: fold into the CRC
         crc_in = crc_byte_update(crc_ff, stage.data_byte);
         pos_in = pos_ff + 1'b1;
      end else if (pos_ff == POS_CRC0) begin
         // first CRC slot: low byte
         if (seal) begin
            out_byte_in = crc_fin[7:0];
            first_in    = 1'b0;
         end else begin
            first_in = (stage.data_byte == crc_fin[7:0]);
         end
         pos_in = pos_ff + 1'b1;
      end else begin
         // last byte: CRC bits 15:8, close the frame
         frame_end_in = 1'b1;
         if (seal) begin
            out_byte_in = crc_fin[15:8];
         end else begin
            frame_ok_in = first_ff && (stage.data_byte == crc_fin[15:8]);
         end
         crc_in   = CRC_INIT;
         pos_in   = '0;
         first_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         pos_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            crc_ff   <= crc_in;
            pos_ff   <= pos_in;
            first_ff <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff  <= out_byte_in;
         frame_end_ff <= frame_end_in;
         frame_ok_ff  <= frame_ok_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.frame_end = frame_end_ff;
   assign rsp_chan.frame_ok  = frame_ok_ff;

endmodule

[rtl/crc32_frame_check_and_seal.sv]
// Top level of the CRC-32 frame checker/sealer: input register, frame logic, registers.
// Depends on crc32fc_pkg, crc32fc_if, crc32fc_csr, crc32fc_in_stage, crc32fc_frame.
//
//   Channel    Direction  Handshake          Payload
//   req_chan   in         valid/ready        data_byte[7:0]
//   rsp_chan   out        valid/ready        out_byte[7:0], frame_end, frame_ok
//   csr_*      in         APB write/read     operation_mode (bit 0 at address 0)
//
// One item per clock sustained while rsp_chan is ready. An accepted item passes
// the input register, then the response register, before it shows on rsp_chan.
// The byte-wide CRC update between those two registers sets the clock-to-clock
// path.
// Reset (synchronous, active high) clears mode to check, the CRC to all ones,
// the byte position to zero and both valid flags.
// A stall on rsp_chan holds the input register and, once it is full, lowers
// req_chan.ready; no item is dropped or repeated.
module crc32_frame_check_and_seal #(
   parameter int FRAME_LEN = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   crc32fc_req_if.sink                        req_chan,
   crc32fc_rsp_if.source                      rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [crc32fc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [crc32fc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [crc32fc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import crc32fc_pkg::*;

   mode_type  mode;
   stage_type stage;
   logic      take;

   // Register port: operation_mode, sampled by the frame logic on every item.
   crc32fc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   // Hold the incoming byte until the frame logic can retire it.
   crc32fc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   // Advance the CRC and position; load the response register.
   crc32fc_frame #(
      .FRAME_LEN (FRAME_LEN)
   ) u_frame (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .mode     (mode),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/crc32fc_checker.sv]
// Port-level checker for crc32_frame_check_and_seal, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module crc32fc_checker #(
   parameter int FRAME_LEN = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       frame_end,
   input logic       frame_ok
);
   localparam int               CNT_W    = $clog2(FRAME_LEN);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             at_last;
   logic             stall;
   logic [9:0]       beat;

   assign stall = rsp_valid && !rsp_ready;
   assign beat  = {out_byte, frame_end, frame_ok};

   // Count delivered items within the frame.
   always_comb begin
      cnt_in = cnt_ff;
      if (rsp_valid && rsp_ready) begin
         cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + 1'b1;
      end
   end

   assign at_last = (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_NO_RST(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "valid after reset")
   `ASSERT_CLK(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(beat), "held item changed")
   `ASSERT_CLK(a_end_pos, clock, reset, rsp_valid |-> frame_end == at_last, "frame_end misplaced")
   `ASSERT_CLK(a_ok_at_end, clock, reset, rsp_valid && frame_ok |-> frame_end, "stray frame_ok")

endmodule

bind crc32_frame_check_and_seal crc32fc_checker #(
   .FRAME_LEN (FRAME_LEN)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_byte  (rsp_chan.out_byte),
   .frame_end (rsp_chan.frame_end),
   .frame_ok  (rsp_chan.frame_ok)
);
